@@ design/nnc_pkg.sv @@
// Shared constants, types and pitch table for the nearest note classifier.
package nnc_pkg;

    // Fixed field widths
    localparam int FREQ_W      = 24;
    localparam int INDEX_W     = 4;
    localparam int TOL_W       = 12;

    // Internal extra fraction bits carried by every frequency
    localparam int XF          = 12;

    // Integer bits of the largest reference pitch (1046.50 Hz < 2048)
    localparam int PITCH_INT_W = 11;

    // Pitch table depth and its index width
    localparam int TABLE_LEN   = 16;
    localparam int TABLE_IDX_W = 4;

    // Parameter defaults
    localparam int DEF_NUM_PITCHES    = 12;
    localparam int DEF_FREQ_FRAC_BITS = 10;

    // APB register port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Register index codes (word address bit of paddr)
    localparam logic REG_TOL   = 1'b0;

    // Reset value of the tolerance register, about 0.1 in Q0.12
    localparam logic [TOL_W-1:0] TOL_RESET = 12'd410;

    // Reference pitches in hundredths of a hertz, A4 .. G#5 then A5 .. C6
    localparam logic [16:0] PITCH_CENTI [TABLE_LEN] = '{
        17'd44000, 17'd46616, 17'd49388, 17'd52325,
        17'd55437, 17'd58733, 17'd62225, 17'd65925,
        17'd69846, 17'd73999, 17'd78399, 17'd83061,
        17'd88000, 17'd93232, 17'd98776, 17'd104650
    };

    // Compare flags from the shared unit
    typedef struct packed {
        logic gt;
        logic lt;
    } nnc_cmp_t;

    // Reference pitch k with ffb fraction bits plus XF extra bits, truncated.
    // Only called with constant arguments, so it folds at elaboration.
    function automatic logic [63:0] ref_pitch(input int k, input int ffb);
        logic [63:0] scaled;
        scaled = 64'(PITCH_CENTI[k]) << (ffb + XF);
        return scaled / 64'd100;
    endfunction

endpackage

@@ design/nnc_if.sv @@
// Valid/ready channel interfaces for measured frequency and note result beats.
interface nnc_freq_if;
    logic                        valid;
    logic                        ready;
    logic [nnc_pkg::FREQ_W-1:0]  measured_freq;

    modport source (output valid, output measured_freq, input ready);
    modport sink   (input valid, input measured_freq, output ready);
endinterface

interface nnc_note_if;
    logic                        valid;
    logic                        ready;
    logic [nnc_pkg::INDEX_W-1:0] note_index;
    logic                        note_matched;
    logic [nnc_pkg::FREQ_W-1:0]  folded_freq;
    logic [nnc_pkg::FREQ_W-1:0]  freq_difference;

    modport source (output valid, output note_index, output note_matched,
                    output folded_freq, output freq_difference, input ready);
    modport sink   (input valid, input note_index, input note_matched,
                    input folded_freq, input freq_difference, output ready);
endinterface

@@ design/nnc_cmp_unit.sv @@
// Shared magnitude compare and absolute difference unit.
module nnc_cmp_unit #(
    parameter int W = 51
) (
    input  logic [W-1:0]      a,
    input  logic [W-1:0]      b,
    output nnc_pkg::nnc_cmp_t flags,
    output logic [W-1:0]      abs_diff
);
    import nnc_pkg::*;

    logic [W:0] sub_ab;

    // One subtract gives both the ordering and the magnitude
    assign sub_ab   = {1'b0, a} - {1'b0, b};
    assign flags.lt = sub_ab[W];
    assign flags.gt = !sub_ab[W] && (sub_ab[W-1:0] != '0);
    assign abs_diff = sub_ab[W] ? (b - a) : sub_ab[W-1:0];

endmodule

@@ design/nearest_note_classifier.sv @@
// Top level of the nearest note classifier: sequencer, tolerance register, result beat.
//
// Takes one measured frequency (unsigned Q14.10 Hz) and returns the nearest chromatic
// pitch after octave folding, its folded frequency, the absolute difference and a match
// flag against the programmable tolerance. One compare/subtract unit is shared by the
// halve, double, difference, best and match steps. For each pitch the sequencer
// loads the reference, halves it while above twice the input, doubles it while below
// half the input, takes the difference and keeps the best; after the last pitch it
// multiplies, checks the match and finishes. A zero input skips the search and goes
// straight to finish. The input is not ready until the current item is handed to the
// output register; a finished result may wait there while the next item runs.
// tolerance_fraction sits at byte address 0 of the APB port and should only be written
// while no item is in flight.
module nearest_note_classifier #(
    parameter int NUM_PITCHES    = nnc_pkg::DEF_NUM_PITCHES,
    parameter int FREQ_FRAC_BITS = nnc_pkg::DEF_FREQ_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nnc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [nnc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [nnc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    nnc_freq_if.sink                        freq_ch,
    nnc_note_if.source                      note_ch
);
    import nnc_pkg::*;

    // Internal widths
    localparam int FXW    = FREQ_W + XF;                    // extended input
    localparam int REF_W  = PITCH_INT_W + FREQ_FRAC_BITS + XF;
    localparam int RW     = (REF_W > FXW + 1) ? REF_W : FXW + 1;
    localparam int CW     = RW + TOL_W;                     // match compare width
    localparam logic [TABLE_IDX_W-1:0] LAST_K = TABLE_IDX_W'(NUM_PITCHES - 1);

    // Sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LOAD   = 4'd1;
    localparam logic [3:0] ST_HALVE  = 4'd2;
    localparam logic [3:0] ST_DOUBLE = 4'd3;
    localparam logic [3:0] ST_DIFF   = 4'd4;
    localparam logic [3:0] ST_BEST   = 4'd5;
    localparam logic [3:0] ST_MULT   = 4'd6;
    localparam logic [3:0] ST_MATCH  = 4'd7;
    localparam logic [3:0] ST_FINISH = 4'd8;

    // Reference pitch constants at this fraction width
    logic [RW-1:0] ref_tab [TABLE_LEN];
    for (genvar g = 0; g < TABLE_LEN; g++) begin : g_ref
        assign ref_tab[g] = RW'(ref_pitch(g, FREQ_FRAC_BITS));
    end

    // Control state
    logic [3:0]             state_reg, state_next;
    logic [TABLE_IDX_W-1:0] k_reg, k_next;
    logic [TOL_W-1:0]       tol_reg, tol_next;
    logic                   out_valid_reg, out_valid_next;

    // Datapath registers
    logic [FREQ_W-1:0]      f_reg, f_next;
    logic [RW-1:0]          r_reg, r_next;
    logic [RW-1:0]          d_reg, d_next;
    logic [RW-1:0]          best_r_reg, best_r_next;
    logic [RW-1:0]          best_d_reg, best_d_next;
    logic [TABLE_IDX_W-1:0] best_k_reg, best_k_next;
    logic [CW-1:0]          prod_reg, prod_next;
    logic                   match_reg, match_next;

    // Output beat registers
    logic [INDEX_W-1:0]     out_index_reg, out_index_next;
    logic                   out_match_reg, out_match_next;
    logic [FREQ_W-1:0]      out_folded_reg, out_folded_next;
    logic [FREQ_W-1:0]      out_diff_reg, out_diff_next;

    // Shared unit hookup
    logic [CW-1:0]          op_a, op_b, cmp_diff;
    nnc_cmp_t               cmp_flags;

    logic [FXW-1:0]         fx;
    logic                   out_free;
    logic                   out_load;
    logic                   cfg_wr;
    logic [FREQ_W-1:0]      folded_sat, diff_sat;

    nnc_cmp_unit #(
        .W (CW)
    ) u_cmp (
        .a        (op_a),
        .b        (op_b),
        .flags    (cmp_flags),
        .abs_diff (cmp_diff)
    );

    assign fx       = {f_reg, {XF{1'b0}}};
    assign out_free = !out_valid_reg || note_ch.ready;

    // APB register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[APB_ADDR_W-1] == REG_TOL);
    assign prdata = (paddr[APB_ADDR_W-1] == REG_TOL) ? APB_DATA_W'(tol_reg) : '0;

    always_comb
    begin
        tol_next = cfg_wr ? pwdata[TOL_W-1:0] : tol_reg;
    end

    // Saturate the winning values to the output range
    assign folded_sat = (best_r_reg[RW-1:FXW] != '0) ? {FREQ_W{1'b1}}
                                                     : best_r_reg[FXW-1:XF];
    assign diff_sat   = (best_d_reg[RW-1:FXW] != '0) ? {FREQ_W{1'b1}}
                                                     : best_d_reg[FXW-1:XF];

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        f_next      = f_reg;
        r_next      = r_reg;
        d_next      = d_reg;
        best_r_next = best_r_reg;
        best_d_next = best_d_reg;
        best_k_next = best_k_reg;
        prod_next   = prod_reg;
        match_next  = match_reg;
        out_load    = 1'b0;
        op_a        = '0;
        op_b        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (freq_ch.valid)
                begin
                    f_next = freq_ch.measured_freq;
                    k_next = '0;
                    if (freq_ch.measured_freq == '0)
                    begin
                        // No signal: all-zero result
                        best_k_next = '0;
                        best_r_next = '0;
                        best_d_next = '0;
                        match_next  = 1'b0;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                r_next     = ref_tab[k_reg];
                state_next = ST_HALVE;
            end
            ST_HALVE:
            begin
                // Halve while above twice the input
                op_a = CW'(r_reg);
                op_b = CW'({fx, 1'b0});
                if (cmp_flags.gt)
                begin
                    r_next = r_reg >> 1;
                end
                else
                begin
                    state_next = ST_DOUBLE;
                end
            end
            ST_DOUBLE:
            begin
                // Double while below half the input
                op_a = CW'(r_reg);
                op_b = CW'(fx >> 1);
                if (cmp_flags.lt)
                begin
                    r_next = r_reg << 1;
                end
                else
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                op_a       = CW'(fx);
                op_b       = CW'(r_reg);
                d_next     = cmp_diff[RW-1:0];
                state_next = ST_BEST;
            end
            ST_BEST:
            begin
                // Strictly smaller wins, so earlier pitches keep ties
                op_a = CW'(d_reg);
                op_b = CW'(best_d_reg);
                if ((k_reg == '0) || cmp_flags.lt)
                begin
                    best_d_next = d_reg;
                    best_r_next = r_reg;
                    best_k_next = k_reg;
                end
                if (k_reg == LAST_K)
                begin
                    state_next = ST_MULT;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_MULT:
            begin
                prod_next  = CW'(best_r_reg) * CW'(tol_reg);
                state_next = ST_MATCH;
            end
            ST_MATCH:
            begin
                // diff * 4096 <= folded * tolerance
                op_a       = {best_d_reg, {TOL_W{1'b0}}};
                op_b       = prod_reg;
                match_next = !cmp_flags.gt;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output beat
    always_comb
    begin
        out_valid_next  = out_load || (out_valid_reg && !note_ch.ready);
        out_index_next  = out_load ? INDEX_W'(best_k_reg) : out_index_reg;
        out_match_next  = out_load ? match_reg : out_match_reg;
        out_folded_next = out_load ? folded_sat : out_folded_reg;
        out_diff_next   = out_load ? diff_sat : out_diff_reg;
    end

    assign freq_ch.ready           = (state_reg == ST_IDLE);
    assign note_ch.valid           = out_valid_reg;
    assign note_ch.note_index      = out_index_reg;
    assign note_ch.note_matched    = out_match_reg;
    assign note_ch.folded_freq     = out_folded_reg;
    assign note_ch.freq_difference = out_diff_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            tol_reg       <= TOL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            tol_reg       <= tol_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        f_reg          <= f_next;
        r_reg          <= r_next;
        d_reg          <= d_next;
        best_r_reg     <= best_r_next;
        best_d_reg     <= best_d_next;
        best_k_reg     <= best_k_next;
        prod_reg       <= prod_next;
        match_reg      <= match_next;
        out_index_reg  <= out_index_next;
        out_match_reg  <= out_match_next;
        out_folded_reg <= out_folded_next;
        out_diff_reg   <= out_diff_next;
    end

    // A zero input skips the search
    a_zero_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (freq_ch.valid && freq_ch.ready && (freq_ch.measured_freq == '0))
        |=> (state_reg == ST_FINISH))
        else $error("zero input did not go straight to finish");

    // Folding leaves the reference inside the window around the input
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIFF)
        |-> ((RW'(r_reg) >= RW'(fx >> 1)) && (RW'(r_reg) <= RW'({fx, 1'b0}))))
        else $error("folded reference outside half..twice window");

    // Pitch counter stays within the configured table
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (k_reg <= LAST_K))
        else $error("pitch counter beyond last pitch");

    // A delivered index always names a configured pitch
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        note_ch.valid |-> (note_ch.note_index <= INDEX_W'(LAST_K)))
        else $error("result index beyond last pitch");

endmodule
